// File: hw/rtl/aqp_pkg.sv
`timescale 1ns / 1ps

package aqp_pkg;

    localparam int unsigned PosW = 17;

    localparam logic [31:0] MagicReset = 32'hFF544347;
    localparam logic [15:0] TypeReset  = 16'h8018;

    localparam logic [15:0] HdrLen   = 16'd6;
    localparam logic [15:0] ClockLen = 16'd17;
    localparam logic [15:0] FwLen    = 16'd8;

    // Register indexes, decoded from paddr[2]
    localparam logic REG_MAGIC = 1'b0;
    localparam logic REG_TYPE  = 1'b1;

    typedef enum logic [12:0] {
        PH_IDLE     = 13'b0000000000001,
        PH_HDR      = 13'b0000000000010,
        PH_NAMESZ   = 13'b0000000000100,
        PH_SKIPNAME = 13'b0000000001000,
        PH_DATASZ   = 13'b0000000010000,
        PH_DATA     = 13'b0000000100000,
        PH_SKIPCLK  = 13'b0000001000000,
        PH_PCRCNT   = 13'b0000010000000,
        PH_HASH     = 13'b0000100000000,
        PH_SOS      = 13'b0001000000000,
        PH_SKIPSEL  = 13'b0010000000000,
        PH_DGSTSZ   = 13'b0100000000000,
        PH_DIGEST   = 13'b1000000000000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_EXTRA  = 2'd1,
        KIND_DIGEST = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_PENDING    = 4'd0,
        ST_OK         = 4'd1,
        ST_SHORT      = 4'd2,
        ST_MAGIC      = 4'd3,
        ST_TYPE       = 4'd4,
        ST_NAMESZ     = 4'd5,
        ST_DATASZ     = 4'd6,
        ST_DATA       = 4'd7,
        ST_CLOCK      = 4'd8,
        ST_FIRMWARE   = 4'd9,
        ST_PCRCNT     = 4'd10,
        ST_SELECTION  = 4'd11,
        ST_DGSTSZ     = 4'd12,
        ST_DIGEST     = 4'd13
    } status_t;

endpackage

// File: hw/rtl/attest_quote_parser_unit.sv
`timescale 1ns / 1ps

// Attestation quote parser.
// Record bytes enter on the s_ channel one item per byte; s_first_byte marks
// the first byte of a record and s_record_size is sampled with it. Every
// accepted byte produces exactly one item on the m_ channel: the copied
// extra-data or digest byte (m_out_kind 1 or 2) or an empty item (kind 0),
// always with the current parse status and the length of the field being
// copied. Status 1 means the quote parsed; 2 to 13 name the first failed check,
// after which the rest of the record is ignored until the next first byte.
// The expected magic word and structure tag are APB registers at 0x0 and 0x4,
// to be written only while no item is in flight.
// Throughput is one byte per cycle while the receiver keeps up. Each byte passes
// through the input register, then the parse step that loads the result register. When the
// receiver stalls, the result register holds and the input register fills,
// then s_ready drops; nothing is lost. Synchronous reset (aresetn low) empties
// both registers, restores the register defaults and leaves the parser
// finished with status 0, waiting for a first byte.
module attest_quote_parser_unit
    import aqp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [15:0] s_record_size,
    input  logic        s_first_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [1:0]  m_out_kind,
    output logic [3:0]  m_status,
    output logic [15:0] m_payload_size,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration
    logic [31:0] magic_reg;
    logic [15:0] type_reg;

    // Input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic [15:0] in_size_reg;
    logic        in_first_reg;

    // Result register
    logic        m_valid_reg;
    logic [7:0]  m_byte_reg;
    logic [1:0]  m_kind_reg;
    logic [3:0]  m_status_reg;
    logic [15:0] m_plen_reg;

    // Parser state
    phase_t          phase_reg, phase_next;
    logic [PosW-1:0] pos_reg, pos_next;
    logic [31:0]     acc_reg, acc_next;
    logic [15:0]     left_reg, left_next;
    logic [31:0]     sel_reg, sel_next;
    logic [15:0]     size_reg, size_next;
    logic            fin_reg, fin_next;
    logic [3:0]      status_reg, status_next;
    logic [15:0]     plen_reg, plen_next;

    logic [7:0]  res_byte;
    logic [1:0]  res_kind;
    logic [15:0] res_plen;

    logic advance;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = m_byte_reg;
    assign m_out_kind     = m_kind_reg;
    assign m_status       = m_status_reg;
    assign m_payload_size = m_plen_reg;

    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_MAGIC: prdata = magic_reg;
            REG_TYPE:  prdata = {16'd0, type_reg};
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg <= MagicReset;
            type_reg  <= TypeReset;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_MAGIC: magic_reg <= pwdata;
                REG_TYPE:  type_reg  <= pwdata[15:0];
                default:   ;
            endcase
        end
    end

    // One parse step for the byte in the input register.
    always_comb begin
        logic [PosW-1:0] p;
        logic [PosW-1:0] nxt;
        logic [17:0]     n18;
        logic [17:0]     s18;
        logic [17:0]     v18;
        logic [17:0]     t;
        logic [15:0]     v16;
        logic            done;
        logic            do_after;
        logic            do_nextsel;
        logic [17:0]     ai;

        phase_next  = phase_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        left_next   = left_reg;
        sel_next    = sel_reg;
        size_next   = size_reg;
        fin_next    = fin_reg;
        status_next = status_reg;
        plen_next   = plen_reg;
        res_byte    = 8'd0;
        res_kind    = KIND_NONE;
        res_plen    = 16'd0;
        p           = '0;
        nxt         = '0;
        n18         = '0;
        s18         = '0;
        v18         = '0;
        t           = '0;
        v16         = '0;
        done        = 1'b0;
        do_after    = 1'b0;
        do_nextsel  = 1'b0;
        ai          = '0;

        if (in_first_reg) begin
            pos_next    = '0;
            size_next   = in_size_reg;
            fin_next    = 1'b0;
            status_next = ST_PENDING;
            sel_next    = 32'd0;
            if (in_size_reg < HdrLen) begin
                status_next = ST_SHORT;
                fin_next    = 1'b1;
                phase_next  = PH_IDLE;
            end else begin
                phase_next = PH_HDR;
                left_next  = HdrLen;
                acc_next   = 32'd0;
            end
        end

        if (!fin_next) begin
            p        = pos_next;
            nxt      = p + 1'b1;
            n18      = 18'(nxt);
            s18      = {2'b00, size_next};
            pos_next = nxt;

            unique case (phase_next)
                PH_HDR: begin
                    acc_next = {acc_next[23:0], in_byte_reg};
                    if (p == PosW'(3)) begin
                        if (acc_next != magic_reg) begin
                            status_next = ST_MAGIC;
                            fin_next    = 1'b1;
                            phase_next  = PH_IDLE;
                        end else begin
                            acc_next = 32'd0;
                        end
                    end else if (p == PosW'(5)) begin
                        if (acc_next[15:0] != type_reg) begin
                            status_next = ST_TYPE;
                            fin_next    = 1'b1;
                            phase_next  = PH_IDLE;
                        end else if (n18 + 18'd2 >= s18) begin
                            status_next = ST_NAMESZ;
                            fin_next    = 1'b1;
                            phase_next  = PH_IDLE;
                        end else begin
                            phase_next = PH_NAMESZ;
                            left_next  = 16'd2;
                            acc_next   = 32'd0;
                        end
                    end
                end
                PH_NAMESZ, PH_DATASZ, PH_PCRCNT, PH_HASH, PH_DGSTSZ: begin
                    acc_next = {acc_next[23:0], in_byte_reg};
                    if (left_next != 16'd0) begin
                        left_next = left_next - 16'd1;
                    end
                    done = (left_next == 16'd0);
                end
                PH_DATA, PH_DIGEST: begin
                    res_kind = (phase_next == PH_DATA) ? KIND_EXTRA : KIND_DIGEST;
                    res_byte = in_byte_reg;
                    res_plen = plen_reg;
                    if (left_next != 16'd0) begin
                        left_next = left_next - 16'd1;
                    end
                    done = (left_next == 16'd0);
                end
                PH_SKIPNAME, PH_SKIPCLK, PH_SKIPSEL: begin
                    if (left_next != 16'd0) begin
                        left_next = left_next - 16'd1;
                    end
                    done = (left_next == 16'd0);
                end
                PH_SOS: begin
                    t = n18 + {10'd0, in_byte_reg};
                    if (t >= s18) begin
                        status_next = ST_SELECTION;
                        fin_next    = 1'b1;
                        phase_next  = PH_IDLE;
                    end else begin
                        if (sel_next != 32'd0) begin
                            sel_next = sel_next - 32'd1;
                        end
                        if (in_byte_reg == 8'd0) begin
                            do_nextsel = 1'b1;
                            ai         = t;
                        end else begin
                            phase_next = PH_SKIPSEL;
                            left_next  = {8'd0, in_byte_reg};
                            acc_next   = 32'd0;
                        end
                    end
                end
                default: ;
            endcase

            if (done) begin
                v16 = acc_next[15:0];
                v18 = {2'b00, v16};
                unique case (phase_next)
                    PH_NAMESZ: begin
                        if (n18 + v18 + 18'd2 >= s18) begin
                            status_next = ST_DATASZ;
                            fin_next    = 1'b1;
                            phase_next  = PH_IDLE;
                        end else if (v16 == 16'd0) begin
                            phase_next = PH_DATASZ;
                            left_next  = 16'd2;
                            acc_next   = 32'd0;
                        end else begin
                            phase_next = PH_SKIPNAME;
                            left_next  = v16;
                            acc_next   = 32'd0;
                        end
                    end
                    PH_SKIPNAME: begin
                        phase_next = PH_DATASZ;
                        left_next  = 16'd2;
                        acc_next   = 32'd0;
                    end
                    PH_DATASZ: begin
                        if (v18 + n18 > s18) begin
                            status_next = ST_DATA;
                            fin_next    = 1'b1;
                            phase_next  = PH_IDLE;
                        end else if (v16 == 16'd0) begin
                            do_after = 1'b1;
                        end else begin
                            plen_next  = v16;
                            phase_next = PH_DATA;
                            left_next  = v16;
                            acc_next   = 32'd0;
                        end
                    end
                    PH_DATA: begin
                        do_after = 1'b1;
                    end
                    PH_SKIPCLK: begin
                        phase_next = PH_PCRCNT;
                        left_next  = 16'd4;
                        acc_next   = 32'd0;
                    end
                    PH_PCRCNT: begin
                        sel_next   = acc_next;
                        do_nextsel = 1'b1;
                        ai         = n18;
                    end
                    PH_HASH: begin
                        if (n18 + 18'd1 >= s18) begin
                            status_next = ST_SELECTION;
                            fin_next    = 1'b1;
                            phase_next  = PH_IDLE;
                        end else begin
                            phase_next = PH_SOS;
                            left_next  = 16'd1;
                            acc_next   = 32'd0;
                        end
                    end
                    PH_SKIPSEL: begin
                        do_nextsel = 1'b1;
                        ai         = n18;
                    end
                    PH_DGSTSZ: begin
                        if (v18 + n18 > s18) begin
                            status_next = ST_DIGEST;
                            fin_next    = 1'b1;
                            phase_next  = PH_IDLE;
                        end else if (v16 == 16'd0) begin
                            status_next = ST_OK;
                            fin_next    = 1'b1;
                            phase_next  = PH_IDLE;
                        end else begin
                            plen_next  = v16;
                            phase_next = PH_DIGEST;
                            left_next  = v16;
                            acc_next   = 32'd0;
                        end
                    end
                    PH_DIGEST: begin
                        status_next = ST_OK;
                        fin_next    = 1'b1;
                        phase_next  = PH_IDLE;
                    end
                    default: ;
                endcase
            end

            // Clock info, firmware info and the PCR count are checked together before clock and firmware are skipped.
            if (do_after) begin
                if (n18 + 18'(ClockLen) >= s18) begin
                    status_next = ST_CLOCK;
                    fin_next    = 1'b1;
                    phase_next  = PH_IDLE;
                end else if (n18 + 18'(ClockLen) + 18'(FwLen) >= s18) begin
                    status_next = ST_FIRMWARE;
                    fin_next    = 1'b1;
                    phase_next  = PH_IDLE;
                end else if (n18 + 18'(ClockLen) + 18'(FwLen) + 18'd4 >= s18) begin
                    status_next = ST_PCRCNT;
                    fin_next    = 1'b1;
                    phase_next  = PH_IDLE;
                end else begin
                    phase_next = PH_SKIPCLK;
                    left_next  = ClockLen + FwLen;
                    acc_next   = 32'd0;
                end
            end

            // Another selection entry, or the digest header once the list is used up.
            if (do_nextsel) begin
                if (sel_next == 32'd0) begin
                    if (ai + 18'd2 >= s18) begin
                        status_next = ST_DGSTSZ;
                        fin_next    = 1'b1;
                        phase_next  = PH_IDLE;
                    end else begin
                        phase_next = PH_DGSTSZ;
                        left_next  = 16'd2;
                        acc_next   = 32'd0;
                    end
                end else if (ai + 18'd2 >= s18) begin
                    status_next = ST_SELECTION;
                    fin_next    = 1'b1;
                    phase_next  = PH_IDLE;
                end else begin
                    phase_next = PH_HASH;
                    left_next  = 16'd2;
                    acc_next   = 32'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            phase_reg    <= PH_IDLE;
            pos_reg      <= '0;
            acc_reg      <= 32'd0;
            left_reg     <= 16'd0;
            sel_reg      <= 32'd0;
            size_reg     <= 16'd0;
            fin_reg      <= 1'b1;
            status_reg   <= ST_PENDING;
            plen_reg     <= 16'd0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (advance) begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                acc_reg    <= acc_next;
                left_reg   <= left_next;
                sel_reg    <= sel_next;
                size_reg   <= size_next;
                fin_reg    <= fin_next;
                status_reg <= status_next;
                plen_reg   <= plen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_data_byte;
            in_size_reg  <= s_record_size;
            in_first_reg <= s_first_byte;
        end
        if (advance) begin
            m_byte_reg   <= res_byte;
            m_kind_reg   <= res_kind;
            m_status_reg <= status_next;
            m_plen_reg   <= res_plen;
        end
    end

endmodule
